>>> hdl/mm4_pkg.sv
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared types and constants for the 4x4 Q16.16 matrix multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package mm4_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned ACC_W     = PROD_W + 2;   // exact sum of four products
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DIM       = 4;
  localparam int unsigned IDX_W     = 2;            // row / column / k index
  localparam int unsigned ELEM_W    = 2 * IDX_W;    // element address, row-major
  localparam int unsigned NUM_ELEMS = DIM * DIM;

  localparam logic [1:0] MODE_LOAD_LEFT  = 2'd0;
  localparam logic [1:0] MODE_LOAD_RIGHT = 2'd1;
  localparam logic [1:0] MODE_MULTIPLY   = 2'd2;

  localparam logic [IDX_W-1:0]  K_LAST    = IDX_W'(DIM - 1);
  localparam logic [ELEM_W-1:0] ELEM_LAST = ELEM_W'(NUM_ELEMS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_EMIT
  } mm4_state_e;

  // controller -> datapath
  typedef struct packed {
    logic              load_left;
    logic              load_right;
    logic              mul_en;
    logic              acc_clr;
    logic              acc_en;
    logic              out_load;
    logic [IDX_W-1:0]  k;
    logic [ELEM_W-1:0] elem;
  } mm4_cmd_t;

endpackage

`default_nettype wire

>>> hdl/mm4_ctrl.sv
// ----------------------------------------------------------------------------
// mm4_ctrl
// Sequencer: takes load and multiply transactions, walks the 16 product
// elements and the 4 multiply steps of each, and drives the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [1:0]            mode_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output mm4_pkg::mm4_cmd_t          cmd_o
);

  import mm4_pkg::*;

  mm4_state_e        state_q, state_d;
  logic [IDX_W-1:0]  k_q, k_d;
  logic [ELEM_W-1:0] n_q, n_d;
  logic              in_fire;

  assign in_fire = in_valid_i && (state_q == ST_IDLE);

  // next state and counters
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    n_d     = n_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && mode_i == MODE_MULTIPLY) begin
          state_d = ST_MUL;
          k_d     = '0;
          n_d     = '0;
        end
      end
      ST_MUL: begin
        k_d = k_q + IDX_W'(1);
        if (k_q == K_LAST) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_stall_i) begin
          if (n_q == ELEM_LAST) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_MUL;
            k_d     = '0;
            n_d     = n_q + ELEM_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    cmd_o.k     = k_q;
    cmd_o.elem  = n_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o       = 1'b0;
        cmd_o.load_left  = in_valid_i && mode_i == MODE_LOAD_LEFT;
        cmd_o.load_right = in_valid_i && mode_i == MODE_LOAD_RIGHT;
      end
      ST_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.acc_clr = (k_q == '0);
        cmd_o.acc_en  = (k_q != '0);
      end
      ST_ACC: begin
        cmd_o.out_load = 1'b1;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      n_q     <= n_d;
    end
  end

  a_multiply_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && mode_i == MODE_MULTIPLY) |=> (state_q == ST_MUL && k_q == '0 && n_q == '0))
    else $error("multiply transaction did not start the element walk");

  a_last_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !out_stall_i && n_q == ELEM_LAST) |=> (state_q == ST_IDLE))
    else $error("controller did not return to idle after the final element");

  a_no_input_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result is pending");

  a_elem_held_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_stall_i) |=> (state_q == ST_EMIT && $stable(n_q)))
    else $error("element index moved while the output was stalled");

endmodule

`default_nettype wire

>>> hdl/mm4_dp.sv
// ----------------------------------------------------------------------------
// mm4_dp
// Datapath: left and right element stores, one shared 32x32 signed multiplier,
// a 66-bit accumulator and the shift/saturate output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mm4_pkg::mm4_cmd_t             cmd_i,
  input  wire logic [mm4_pkg::IDX_W-1:0]     row_index_i,
  input  wire logic [mm4_pkg::IDX_W-1:0]     col_index_i,
  input  wire logic signed [mm4_pkg::DATA_W-1:0] element_value_i,
  output logic [mm4_pkg::IDX_W-1:0]          out_row_o,
  output logic [mm4_pkg::IDX_W-1:0]          out_col_o,
  output logic signed [mm4_pkg::DATA_W-1:0]  product_value_o,
  output logic                               last_o
);

  import mm4_pkg::*;

  logic signed [DATA_W-1:0] left_q  [NUM_ELEMS];
  logic signed [DATA_W-1:0] right_q [NUM_ELEMS];

  logic [ELEM_W-1:0]        wr_addr;
  logic [ELEM_W-1:0]        left_addr, right_addr;
  logic signed [DATA_W-1:0] left_op, right_op;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  sum;
  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-DATA_W:0]    hi_bits;
  logic signed [DATA_W-1:0] sat_d;

  logic [IDX_W-1:0]         out_row_q, out_col_q;
  logic signed [DATA_W-1:0] product_q;
  logic                     last_q;

  assign wr_addr = {row_index_i, col_index_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ELEMS; i++) begin
        left_q[i]  <= '0;
        right_q[i] <= '0;
      end
    end else begin
      if (cmd_i.load_left) begin
        left_q[wr_addr] <= element_value_i;
      end
      if (cmd_i.load_right) begin
        right_q[wr_addr] <= element_value_i;
      end
    end
  end

  // left[row][k] * right[k][col]
  assign left_addr  = {cmd_i.elem[ELEM_W-1:IDX_W], cmd_i.k};
  assign right_addr = {cmd_i.k, cmd_i.elem[IDX_W-1:0]};
  assign left_op    = left_q[left_addr];
  assign right_op   = right_q[right_addr];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= left_op * right_op;
    end
  end

  assign prod_ext = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign sum      = acc_q + prod_ext;
  assign shifted  = sum >>> FRAC_BITS;
  assign hi_bits  = shifted[ACC_W-1:DATA_W-1];

  // saturate when the bits above the 32-bit range are not all sign copies
  always_comb begin
    if (hi_bits == '0 || hi_bits == '1) begin
      sat_d = shifted[DATA_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      sat_d = {1'b1, {(DATA_W - 1){1'b0}}};
    end else begin
      sat_d = {1'b0, {(DATA_W - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_row_q <= cmd_i.elem[ELEM_W-1:IDX_W];
      out_col_q <= cmd_i.elem[IDX_W-1:0];
      product_q <= sat_d;
      last_q    <= (cmd_i.elem == ELEM_LAST);
    end
  end

  assign out_row_o       = out_row_q;
  assign out_col_o       = out_col_q;
  assign product_value_o = product_q;
  assign last_o          = last_q;

  a_one_store_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.load_left && cmd_i.load_right))
    else $error("both stores written in one cycle");

  a_acc_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.acc_clr && cmd_i.acc_en))
    else $error("accumulator cleared and updated together");

  a_acc_follows_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.acc_en || cmd_i.out_load) |-> $past(cmd_i.mul_en))
    else $error("accumulate without a fresh product");

endmodule

`default_nettype wire

>>> hdl/matrix_multiply_4x4_top.sv
// Load transaction: the element is written, then ready for the next transaction.
// Multiply transaction: 16 results, each from 4 passes through the single
// shared 32x32 multiplier, one final accumulate/saturate step and one output
// step that holds through any output stall. The input side stays stalled
// until the last result has been taken.
// Reset clears both element stores to zero and returns the sequencer to idle.
// ----------------------------------------------------------------------------
// matrix_multiply_4x4_top
// 4x4 signed Q16.16 matrix multiplier with loadable left and right stores.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_4x4_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [1:0]                        mode_i,
  input  wire logic [mm4_pkg::IDX_W-1:0]         row_index_i,
  input  wire logic [mm4_pkg::IDX_W-1:0]         col_index_i,
  input  wire logic signed [mm4_pkg::DATA_W-1:0] element_value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [mm4_pkg::IDX_W-1:0]              out_row_o,
  output logic [mm4_pkg::IDX_W-1:0]              out_col_o,
  output logic signed [mm4_pkg::DATA_W-1:0]      product_value_o,
  output logic                                   last_o
);

  import mm4_pkg::*;

  mm4_cmd_t cmd;

  mm4_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  mm4_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .product_value_o (product_value_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 4x4 Q16.16 matrix multiplier. A scoreboard
// keeps its own copy of both element stores. Each multiply transaction
// queues the 16 row-major products, and the bench compares each one with
// what comes out of the block. Both sides of the handshake idle and stall
// at random.
// ----------------------------------------------------------------------------

module tb;

  import mm4_pkg::*;

  localparam time         CLK_PERIOD  = 12ns;
  localparam int          NUM_ITEMS   = 350;
  localparam int          HOLD_CYCLES = 400;
  localparam int          TAIL_CYCLES = 24;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;

  typedef struct {
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } product_t;

  // --------------------------------------------------------------------------
  class mm4_scoreboard;
    logic signed [DATA_W-1:0] left_m[NUM_ELEMS];
    logic signed [DATA_W-1:0] right_m[NUM_ELEMS];
    product_t                 product_q[$];
    int                       errors;

    function new();
      foreach (left_m[i]) begin
        left_m[i]  = '0;
        right_m[i] = '0;
      end
      errors = 0;
    endfunction

    // exact dot product, floor shift, then clamp to 32 bits
    function logic signed [DATA_W-1:0] dot(int r, int c);
      localparam logic signed [ACC_W-1:0] SAT_HI = 66'sd2147483647;
      localparam logic signed [ACC_W-1:0] SAT_LO = -66'sd2147483648;
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] shifted;
      longint                  term;
      acc = '0;
      for (int k = 0; k < DIM; k++) begin
        term = longint'(left_m[r * DIM + k]) * longint'(right_m[k * DIM + c]);
        acc  = acc + term;
      end
      shifted = acc >>> FRAC_BITS;
      if (shifted > SAT_HI) return 32'sh7FFF_FFFF;
      if (shifted < SAT_LO) return 32'sh8000_0000;
      return shifted[DATA_W-1:0];
    endfunction

    function void note_input(logic [1:0] mode, logic [IDX_W-1:0] row,
                             logic [IDX_W-1:0] col, logic signed [DATA_W-1:0] value);
      product_t p;
      case (mode)
        MODE_LOAD_LEFT:  left_m[{row, col}]  = value;
        MODE_LOAD_RIGHT: right_m[{row, col}] = value;
        MODE_MULTIPLY: begin
          for (int n = 0; n < NUM_ELEMS; n++) begin
            p.row   = n[3:2];
            p.col   = n[1:0];
            p.value = dot(n / DIM, n % DIM);
            p.last  = (n == NUM_ELEMS - 1);
            product_q.push_back(p);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_product(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                logic signed [DATA_W-1:0] value, logic last);
      product_t p;
      if (product_q.size() == 0) begin
        $display("%0t: unexpected product (%0d,%0d) value %0d last %0b",
                 $time, row, col, value, last);
        errors++;
        return;
      end
      p = product_q.pop_front();
      if (row !== p.row) begin
        $display("%0t: out_row expected %0d actual %0d", $time, p.row, row);
        errors++;
      end
      if (col !== p.col) begin
        $display("%0t: out_col expected %0d actual %0d", $time, p.col, col);
        errors++;
      end
      if (value !== p.value) begin
        $display("%0t: product_value (%0d,%0d) expected %0d actual %0d",
                 $time, p.row, p.col, p.value, value);
        errors++;
      end
      if (last !== p.last) begin
        $display("%0t: last (%0d,%0d) expected %0b actual %0b",
                 $time, p.row, p.col, p.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return product_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  logic                     clk_i           = 1'b0;
  logic                     rst_ni          = 1'b0;
  logic                     in_valid_i      = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               mode_i          = MODE_LOAD_LEFT;
  logic [IDX_W-1:0]         row_index_i     = '0;
  logic [IDX_W-1:0]         col_index_i     = '0;
  logic signed [DATA_W-1:0] element_value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i     = 1'b0;
  logic [IDX_W-1:0]         out_row_o;
  logic [IDX_W-1:0]         out_col_o;
  logic signed [DATA_W-1:0] product_value_o;
  logic                     last_o;

  mm4_scoreboard sb = new();

  int items_sent  = 0;
  int burst_left  = 8;
  int hold_asked  = 0;
  int hold_done   = 0;

  matrix_multiply_4x4_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .product_value_o (product_value_o),
    .last_o          (last_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("tb: done, errors");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_product(out_row_o, out_col_o, product_value_o, last_o);
  end

  // receiver: stall pattern changes at random intervals; long hold on request
  initial begin
    int pat;
    int pat_left;
    bit toggle;
    pat      = 0;
    pat_left = 0;
    toggle   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_asked != hold_done) begin
        hold_done = hold_asked;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        if (pat_left == 0) begin
          pat      = $urandom_range(0, 3);
          pat_left = $urandom_range(16, 96);
        end
        pat_left--;
        toggle = ~toggle;
        case (pat)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= toggle;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] mode, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] value);
    int gap;
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    mode_i          <= mode;
    row_index_i     <= row;
    col_index_i     <= col;
    element_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(mode, row, col, value);
    if (mode != MODE_UNUSED) items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic multiply();
    send_item(MODE_MULTIPLY, 2'($urandom()), 2'($urandom()), $urandom());
  endtask

  task automatic load(input logic [1:0] mode, input int r, input int c,
                      input logic [DATA_W-1:0] value);
    send_item(mode, IDX_W'(r), IDX_W'(c), value);
  endtask

  // 0: small Q16.16 (about +/-4.0), 1: any 32 bits, 2: corner values, else mixed
  function automatic logic [DATA_W-1:0] pick_value(int kind);
    if (kind > 2) kind = $urandom_range(0, 2);
    case (kind)
      0: return 32'($urandom_range(0, 32'h7_FFFF)) - 32'h4_0000;
      1: return $urandom();
      default: begin
        case ($urandom_range(0, 6))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          3:       return 32'h0000_0001;
          4:       return 32'hFFFF_FFFF;
          5:       return 32'h0001_0000;
          default: return 32'hFFFF_0000;
        endcase
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  initial begin
    int order[2 * NUM_ELEMS];
    int seq;
    int kind_l;
    int kind_r;
    int j;
    int tmp;
    int e;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero stores, unused mode, saturation both ways, floor rounding
    multiply();
    send_item(MODE_UNUSED, 2'd0, 2'd0, 32'h7FFF_FFFF);
    load(MODE_LOAD_LEFT,  0, 0, 32'h7FFF_FFFF);
    load(MODE_LOAD_LEFT,  0, 1, 32'h7FFF_FFFF);
    load(MODE_LOAD_RIGHT, 0, 0, 32'h7FFF_FFFF);
    load(MODE_LOAD_RIGHT, 1, 0, 32'h7FFF_FFFF);
    load(MODE_LOAD_RIGHT, 0, 1, 32'h8000_0000);
    load(MODE_LOAD_RIGHT, 1, 1, 32'h8000_0000);
    load(MODE_LOAD_LEFT,  3, 3, 32'hFFFF_FFFF);
    load(MODE_LOAD_RIGHT, 3, 3, 32'h0000_0001);
    load(MODE_LOAD_LEFT,  1, 0, 32'h0001_0000);
    load(MODE_LOAD_RIGHT, 0, 2, 32'h0001_8000);
    load(MODE_LOAD_LEFT,  2, 3, 32'h8000_0000);
    load(MODE_LOAD_RIGHT, 3, 2, 32'h8000_0000);
    multiply();
    send_item(MODE_UNUSED, 2'd3, 2'd3, 32'h8000_0000);
    multiply();

    seq = 0;
    while (items_sent < NUM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          // full reload of both stores in random order, then multiply
          kind_l = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
          kind_r = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
          foreach (order[i]) order[i] = i;
          for (int i = 2 * NUM_ELEMS - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
          end
          foreach (order[i]) begin
            e = order[i];
            if (e < NUM_ELEMS)
              load(MODE_LOAD_LEFT, e / DIM, e % DIM, pick_value(kind_l));
            else
              load(MODE_LOAD_RIGHT, (e - NUM_ELEMS) / DIM, e % DIM, pick_value(kind_r));
          end
          multiply();
        end
        6, 7: begin
          repeat ($urandom_range(1, 6))
            send_item($urandom_range(0, 1) ? MODE_LOAD_RIGHT : MODE_LOAD_LEFT,
                      2'($urandom()), 2'($urandom()), pick_value($urandom_range(0, 3)));
          multiply();
        end
        8: begin
          repeat ($urandom_range(1, 4))
            send_item(MODE_UNUSED, 2'($urandom()), 2'($urandom()), $urandom());
          send_item($urandom_range(0, 1) ? MODE_LOAD_RIGHT : MODE_LOAD_LEFT,
                    2'($urandom()), 2'($urandom()), $urandom());
        end
        default: begin
          multiply();
          multiply();
        end
      endcase

      // long output hold while the input keeps getting offered work
      if (seq == 2) begin
        hold_asked++;
        multiply();
        repeat (3)
          send_item(MODE_LOAD_LEFT, 2'($urandom()), 2'($urandom()), pick_value(0));
        multiply();
      end
      if (seq == 5 || $urandom_range(0, 7) == 0) wait_drained();
      seq++;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
